@@ rtl/core/cowa_pkg.sv @@
// cowa_pkg: shared widths, constants, controller states and the command and
// status structs of the clock offset window averager
// no dependencies
package cowa_pkg;

   localparam int unsigned DEPTH_DEF  = 512;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned COUNT_W    = 10;
   // est*5 + mean in two's complement, magnitude at most 6 * 2^31
   localparam int unsigned SMOOTH_W   = 36;
   localparam int unsigned MEAN_W     = TIME_W + 1;

   // divide by six: halve the magnitude (below 2^33), multiply by ceil(2^35/3)
   // and keep bits 35 and up; the low multiplier slice is RECIP_LO_W bits
   localparam int unsigned HALF_W      = TIME_W + 1;
   localparam int unsigned RECIP_W     = 34;
   localparam int unsigned RECIP_LO_W  = 17;
   localparam int unsigned THIRD_SHIFT = 35;
   localparam logic [RECIP_W-1:0] THIRD_RECIP = 34'h2_AAAA_AAAB;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MEAN_START,
      ST_MEAN_DIV,
      ST_SMOOTH_PREP,
      ST_SMOOTH_START,
      ST_SMOOTH_LO,
      ST_SMOOTH_HI,
      ST_SMOOTH_LATCH,
      ST_OUTPUT
   } ctrl_state_type;

   typedef struct packed {
      logic load_sample;
      logic update;
      logic mean_start;
      logic mean_latch;
      logic smooth_prep;
      logic smooth_start;
      logic smooth_lo;
      logic smooth_hi;
      logic smooth_latch;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_status_type;

endpackage

@@ rtl/core/cowa_req_if.sv @@
// cowa_req_if: input channel carrying one time sample per transfer
// depends on cowa_pkg
interface cowa_req_if;
   logic                          valid;
   logic                          ready;
   logic [cowa_pkg::TIME_W-1:0]   server_time;
   logic [cowa_pkg::TIME_W-1:0]   local_time;
   logic [cowa_pkg::TIME_W-1:0]   round_trip;

   modport source (output valid, server_time, local_time, round_trip, input ready);
   modport sink   (input valid, server_time, local_time, round_trip, output ready);
endinterface

@@ rtl/core/cowa_rsp_if.sv @@
// cowa_rsp_if: result channel carrying smoothed offset, window mean and count
// depends on cowa_pkg
interface cowa_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [cowa_pkg::TIME_W-1:0]   smoothed_offset;
   logic signed [cowa_pkg::TIME_W-1:0]   window_mean;
   logic        [cowa_pkg::COUNT_W-1:0]  sample_count;

   modport source (output valid, smoothed_offset, window_mean, sample_count, input ready);
   modport sink   (input valid, smoothed_offset, window_mean, sample_count, output ready);
endinterface

@@ rtl/core/cowa_div.sv @@
// cowa_div: unsigned restoring divider, two quotient bits per cycle
// no package dependencies; divides the window sum by the sample count
module cowa_div #(
   parameter int unsigned DW = 42,
   parameter int unsigned QW = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [QW-1:0] divisor,
   output logic [DW-1:0] quotient,
   output logic [QW-1:0] remainder,
   output logic          done
);

   localparam int unsigned STEPS = DW / 2;
   localparam int unsigned CW    = $clog2(STEPS + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [QW-1:0] rem_ff, rem_in;
   logic [QW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [QW:0]   trial1, trial2;
   logic [QW-1:0] rem1;
   logic          qbit1, qbit2;

   // two dependent restoring steps on the narrow remainder
   always_comb begin
      trial1 = {rem_ff, quo_ff[DW-1]};
      qbit1  = (trial1 >= {1'b0, dvs_ff});
      rem1   = qbit1 ? QW'(trial1 - {1'b0, dvs_ff}) : trial1[QW-1:0];
      trial2 = {rem1, quo_ff[DW-2]};
      qbit2  = (trial2 >= {1'b0, dvs_ff});
      rem_in = qbit2 ? QW'(trial2 - {1'b0, dvs_ff}) : trial2[QW-1:0];
   end

   always_comb begin
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-3:0], qbit1, qbit2};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (start) begin
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

@@ rtl/core/cowa_dp.sv @@
// cowa_dp: datapath with sample ring, running sum, rounding, smoothing and
// result registers; depends on cowa_pkg and cowa_div
module cowa_dp #(
   parameter int unsigned DEPTH = cowa_pkg::DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cowa_pkg::dp_cmd_type                 cmd,
   output cowa_pkg::dp_status_type              status,
   input  logic        [cowa_pkg::TIME_W-1:0]   server_time,
   input  logic        [cowa_pkg::TIME_W-1:0]   local_time,
   input  logic        [cowa_pkg::TIME_W-1:0]   round_trip,
   output logic signed [cowa_pkg::TIME_W-1:0]   smoothed_offset,
   output logic signed [cowa_pkg::TIME_W-1:0]   window_mean,
   output logic        [cowa_pkg::COUNT_W-1:0]  sample_count
);

   localparam int unsigned TW      = cowa_pkg::TIME_W;
   localparam int unsigned MW      = cowa_pkg::MEAN_W;
   localparam int unsigned XW      = cowa_pkg::SMOOTH_W;
   localparam int unsigned HW      = cowa_pkg::HALF_W;
   localparam int unsigned RW      = cowa_pkg::RECIP_W;
   localparam int unsigned LW      = cowa_pkg::RECIP_LO_W;
   localparam int unsigned UW      = HW - LW;
   localparam int unsigned PW      = HW + RW;
   localparam int unsigned SLOT_W  = $clog2(DEPTH);
   localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W   = TW + $clog2(DEPTH);
   localparam int unsigned DW      = SUM_W + (SUM_W % 2);
   localparam int unsigned QW      = CNT_W;

   logic [TW-1:0]            ring_mem [DEPTH];
   logic [TW-1:0]            rd_ff;

   logic [TW-1:0]            sample_ff;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [TW-1:0]     est_ff, est_in;
   logic signed [MW-1:0]     mean_ff;
   logic signed [XW-1:0]     x_ff;
   logic [HW-1:0]            half_ff;
   logic [PW-1:0]            prod_ff;

   logic signed [TW-1:0]     rsp_smooth_ff;
   logic signed [TW-1:0]     rsp_mean_ff;
   logic [cowa_pkg::COUNT_W-1:0] rsp_count_ff;

   logic                     full;
   logic [SUM_W-1:0]         sum_mag;
   logic [XW-1:0]            x_mag;
   logic [DW-1:0]            div_dividend;
   logic [QW-1:0]            div_divisor;
   logic [DW-1:0]            div_quo;
   logic [QW-1:0]            div_rem;
   logic                     div_done;
   logic                     sum_neg, x_neg, round_up;
   logic [MW-1:0]            q_mean;
   logic [TW-1:0]            q_smooth;
   logic signed [XW-1:0]     est_x, mean_x;
   logic [LW+RW-1:0]         lo_prod;
   logic [UW+RW-1:0]         hi_prod;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign sum_neg = sum_ff[SUM_W-1];
   assign x_neg   = x_ff[XW-1];
   assign sum_mag = sum_neg ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign x_mag   = x_neg ? XW'(-x_ff) : XW'(x_ff);

   assign div_dividend = DW'(sum_mag);
   assign div_divisor  = count_ff;

   cowa_div #(
      .DW (DW),
      .QW (QW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mean_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   assign status.div_done = div_done;

   // divide by six as a reciprocal multiply of the halved magnitude, low slice
   // then high slice into one accumulator
   assign lo_prod = {{RW{1'b0}}, half_ff[LW-1:0]} * {{LW{1'b0}}, cowa_pkg::THIRD_RECIP};
   assign hi_prod = {{RW{1'b0}}, half_ff[HW-1:LW]} * {{UW{1'b0}}, cowa_pkg::THIRD_RECIP};

   // ring: one write port, one registered read port at the current slot
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring_mem[slot_ff] <= sample_ff;
      end
      rd_ff <= ring_mem[slot_ff];
   end

   always_comb begin
      sum_in   = sum_ff + SUM_W'(signed'(sample_ff))
                 - (full ? SUM_W'(signed'(rd_ff)) : SUM_W'(0));
      count_in = full ? count_ff : count_ff + CNT_W'(1);
      slot_in  = (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
   end

   // rounding away from zero folds into one incrementer after the sign flip
   always_comb begin
      q_mean   = div_quo[MW-1:0];
      q_smooth = prod_ff[PW-1:cowa_pkg::THIRD_SHIFT];
      round_up = (div_rem > QW'(count_ff >> 1));
      est_x    = XW'(est_ff);
      mean_x   = XW'(mean_ff);
      est_in   = (x_neg ? ~q_smooth : q_smooth) + TW'(x_neg);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= server_time + (round_trip >> 1) - local_time;
      end
      if (cmd.mean_latch) begin
         mean_ff <= (sum_neg ? ~q_mean : q_mean) + MW'(sum_neg ^ round_up);
      end
      if (cmd.smooth_prep) begin
         x_ff <= (est_x <<< 2) + est_x + mean_x;
      end
      if (cmd.smooth_start) begin
         half_ff <= x_mag[HW:1];
      end
      if (cmd.smooth_lo) begin
         prod_ff <= PW'(lo_prod);
      end else if (cmd.smooth_hi) begin
         prod_ff <= prod_ff + {hi_prod, {LW{1'b0}}};
      end
      if (cmd.out_load) begin
         rsp_smooth_ff <= est_ff;
         rsp_mean_ff   <= mean_ff[TW-1:0];
         rsp_count_ff  <= cowa_pkg::COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         est_ff   <= '0;
      end else begin
         if (cmd.update) begin
            slot_ff  <= slot_in;
            count_ff <= count_in;
            sum_ff   <= sum_in;
         end
         if (cmd.smooth_latch) begin
            est_ff <= est_in;
         end
      end
   end

   assign smoothed_offset = rsp_smooth_ff;
   assign window_mean     = rsp_mean_ff;
   assign sample_count    = rsp_count_ff;

endmodule

@@ rtl/core/cowa_ctrl.sv @@
// cowa_ctrl: sequencing state machine and result valid flag
// depends on cowa_pkg
module cowa_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  cowa_pkg::dp_status_type  status,
   output cowa_pkg::dp_cmd_type     cmd
);

   cowa_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   // the result register can take a new value once the old one transfers
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cowa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cowa_pkg::ST_UPDATE;
            end
         end
         cowa_pkg::ST_UPDATE:       state_in = cowa_pkg::ST_MEAN_START;
         cowa_pkg::ST_MEAN_START:   state_in = cowa_pkg::ST_MEAN_DIV;
         cowa_pkg::ST_MEAN_DIV: begin
            if (status.div_done) begin
               state_in = cowa_pkg::ST_SMOOTH_PREP;
            end
         end
         cowa_pkg::ST_SMOOTH_PREP:  state_in = cowa_pkg::ST_SMOOTH_START;
         cowa_pkg::ST_SMOOTH_START: state_in = cowa_pkg::ST_SMOOTH_LO;
         cowa_pkg::ST_SMOOTH_LO:    state_in = cowa_pkg::ST_SMOOTH_HI;
         cowa_pkg::ST_SMOOTH_HI:    state_in = cowa_pkg::ST_SMOOTH_LATCH;
         cowa_pkg::ST_SMOOTH_LATCH: state_in = cowa_pkg::ST_OUTPUT;
         cowa_pkg::ST_OUTPUT: begin
            if (rsp_free) begin
               state_in = cowa_pkg::ST_IDLE;
            end
         end
         default:                   state_in = cowa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         cowa_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.load_sample = req_valid;
         end
         cowa_pkg::ST_UPDATE:       cmd.update       = 1'b1;
         cowa_pkg::ST_MEAN_START:   cmd.mean_start   = 1'b1;
         cowa_pkg::ST_MEAN_DIV:     cmd.mean_latch   = status.div_done;
         cowa_pkg::ST_SMOOTH_PREP:  cmd.smooth_prep  = 1'b1;
         cowa_pkg::ST_SMOOTH_START: cmd.smooth_start = 1'b1;
         cowa_pkg::ST_SMOOTH_LO:    cmd.smooth_lo    = 1'b1;
         cowa_pkg::ST_SMOOTH_HI:    cmd.smooth_hi    = 1'b1;
         cowa_pkg::ST_SMOOTH_LATCH: cmd.smooth_latch = 1'b1;
         cowa_pkg::ST_OUTPUT:       cmd.out_load     = rsp_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cowa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/clock_offset_window_averager_core.sv @@
// Clock offset window averager. Each sample transfer (server time, local time,
// round trip) yields one offset server + rtt/2 - local, kept in a ring of the
// last DEPTH offsets with a running sum; the result carries the window mean
// (rounded to nearest, ties toward zero), the smoothed offset (old*5 + mean)/6
// and the number of samples held. One sample is processed at a time; its time is
// set mostly by the two-bit-per-cycle divider for the window mean, whose width DW
// is 42 at DEPTH 512; the divide by six is a reciprocal multiply in two steps,
// low slice then high slice. A sample is taken again as soon as the previous
// result sits in the output register; a new result waits in the datapath until
// the one before it transfers. The ring is a single memory with one write and
// one read.
// depends on cowa_pkg, cowa_req_if, cowa_rsp_if, cowa_dp, cowa_ctrl
module clock_offset_window_averager_core #(
   parameter int unsigned DEPTH = cowa_pkg::DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cowa_req_if.sink    req_if,
   cowa_rsp_if.source  rsp_if
);

   cowa_pkg::dp_cmd_type    cmd;
   cowa_pkg::dp_status_type status;

   cowa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cowa_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .server_time     (req_if.server_time),
      .local_time      (req_if.local_time),
      .round_trip      (req_if.round_trip),
      .smoothed_offset (rsp_if.smoothed_offset),
      .window_mean     (rsp_if.window_mean),
      .sample_count    (rsp_if.sample_count)
   );

endmodule

@@ test/tb_clock_offset_window_averager_core.sv @@
// testbench for clock_offset_window_averager_core: random and directed time samples,
// results checked against an in-bench window/smoothing predictor
// depends on cowa_pkg, cowa_req_if, cowa_rsp_if and the core rtl
module tb_clock_offset_window_averager_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH       = cowa_pkg::DEPTH_DEF;
   localparam int unsigned TIME_W      = cowa_pkg::TIME_W;
   localparam int unsigned COUNT_W     = cowa_pkg::COUNT_W;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned DRAIN_WAIT  = 120;
   localparam int unsigned EXP_DEPTH   = 16;

   typedef struct packed {
      logic signed [TIME_W-1:0] smoothed;
      logic signed [TIME_W-1:0] mean;
      logic [COUNT_W-1:0]       count;
   } offset_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;
   logic steady = 1'b0;

   cowa_req_if req_if ();
   cowa_rsp_if rsp_if ();

   assign rsp_if.ready = sink_ready;

   clock_offset_window_averager_core #(
      .DEPTH(DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [TIME_W-1:0] past_offsets [DEPTH];
   int unsigned       next_slot = 0;
   longint            samples_held = 0;
   longint            offset_total = 0;
   logic [TIME_W-1:0] smoothed_est = '0;

   // expected results in transfer order
   offset_result_type expected_results [EXP_DEPTH];
   logic [3:0]        exp_head = '0;
   logic [3:0]        exp_tail = '0;
   int unsigned       exp_pending = 0;

   int unsigned error_count = 0;
   int unsigned samples_sent = 0;
   int unsigned results_checked = 0;
   int unsigned full_window_results = 0;
   longint      peak_total = 0;
   int unsigned stall_cycles = 0;

   function automatic offset_result_type predict_offset_window(
      input logic [TIME_W-1:0] srv,
      input logic [TIME_W-1:0] loc,
      input logic [TIME_W-1:0] rtt
   );
      logic [TIME_W-1:0] sample;
      longint            quot;
      longint            remd;
      longint            smooth;
      offset_result_type res;
      sample = srv + (rtt >> 1) - loc;
      if (samples_held == longint'(DEPTH)) begin
         // oldest sample drops out as the new one takes its slot
         offset_total -= longint'($signed(past_offsets[next_slot]));
      end else begin
         samples_held++;
      end
      past_offsets[next_slot] = sample;
      offset_total += longint'($signed(sample));
      next_slot = (next_slot == DEPTH - 1) ? 0 : next_slot + 1;

      quot = offset_total / samples_held;
      remd = offset_total % samples_held;
      if (remd < 0) remd = -remd;
      // round away from zero only past the half, ties stay
      if (remd > samples_held / 2) quot += (offset_total < 0) ? -1 : 1;

      smooth = (longint'($signed(smoothed_est)) * 5 + quot) / 6;
      smoothed_est = smooth[TIME_W-1:0];

      res.smoothed = smooth[TIME_W-1:0];
      res.mean     = quot[TIME_W-1:0];
      res.count    = samples_held[COUNT_W-1:0];
      return res;
   endfunction

   // receiver stalls
   always @(posedge clock) begin
      sink_ready <= steady ? 1'b1 : ($urandom_range(99) >= 19);
   end

   // predict on each sample transfer, check each result transfer
   always @(posedge clock) begin
      offset_result_type want;
      offset_result_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            expected_results[exp_tail] = predict_offset_window(req_if.server_time,
               req_if.local_time, req_if.round_trip);
            exp_tail = exp_tail + 4'd1;
            exp_pending++;
            if (samples_held == longint'(DEPTH)) full_window_results++;
            if (offset_total > peak_total) peak_total = offset_total;
            if (-offset_total > peak_total) peak_total = -offset_total;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.smoothed = rsp_if.smoothed_offset;
            got.mean     = rsp_if.window_mean;
            got.count    = rsp_if.sample_count;
            if (exp_pending == 0) begin
               $display("%0t ERROR result with none expected: smoothed %0d mean %0d count %0d",
                  $time, got.smoothed, got.mean, got.count);
               error_count++;
            end else begin
               want = expected_results[exp_head];
               exp_head = exp_head + 4'd1;
               exp_pending--;
               results_checked++;
               if (got.smoothed !== want.smoothed) begin
                  $display("%0t ERROR smoothed_offset expected %0d actual %0d",
                     $time, want.smoothed, got.smoothed);
                  error_count++;
               end
               if (got.mean !== want.mean) begin
                  $display("%0t ERROR window_mean expected %0d actual %0d",
                     $time, want.mean, got.mean);
                  error_count++;
               end
               if (got.count !== want.count) begin
                  $display("%0t ERROR sample_count expected %0d actual %0d",
                     $time, want.count, got.count);
                  error_count++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : watchdog
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_sample(
      input logic [TIME_W-1:0] srv,
      input logic [TIME_W-1:0] loc,
      input logic [TIME_W-1:0] rtt
   );
      while (!steady && $urandom_range(99) < 19) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.server_time <= srv;
      req_if.local_time  <= loc;
      req_if.round_trip  <= rtt;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      samples_sent++;
   endtask

   // random server time and round trip, local time chosen to give the offset
   task automatic send_offset(input logic [TIME_W-1:0] offset);
      logic [TIME_W-1:0] srv;
      logic [TIME_W-1:0] rtt;
      srv = $urandom;
      rtt = $urandom;
      send_sample(srv, srv + (rtt >> 1) - offset, rtt);
   endtask

   // fresh window: ties of both signs stay, larger remainders round away
   task automatic test_rounding();
      send_offset(32'sd0);
      send_offset(32'sd1);
      send_offset(32'sd1);
      send_offset(-32'sd5);
      send_offset(-32'sd3);
      send_offset(-32'sd3);
   endtask

   task automatic test_field_extremes();
      send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      send_sample(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
      send_sample(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
      send_sample(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
      send_sample(32'h0000_0000, 32'h8000_0000, 32'h0000_0000);
      send_sample(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0003);
      send_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE);
      send_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
   endtask

   task automatic test_random_mix(input int unsigned count);
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 40)
            send_offset(32'($urandom_range(2000)) - 32'd1000);
         else if (pick < 70)
            send_sample($urandom, $urandom, $urandom);
         else if (pick < 85)
            case ($urandom_range(3))
               0: send_offset(32'h8000_0000);
               1: send_offset(32'h7FFF_FFFF);
               2: send_offset(32'h8000_0001);
               default: send_offset(32'h7FFF_FFFE);
            endcase
         else
            send_offset($urandom);
      end
   endtask

   // a full window of the most negative offset drives the sum to its limit
   task automatic test_window_saturation();
      steady <= 1'b1;
      repeat (DEPTH + 8) send_offset(32'h8000_0000);
      steady <= 1'b0;
   endtask

   // swing back to the most positive offset while old samples leave the window
   task automatic test_window_recovery();
      repeat (60) send_offset(32'h7FFF_FFFF);
   endtask

   initial begin
      req_if.valid       = 1'b0;
      req_if.server_time = '0;
      req_if.local_time  = '0;
      req_if.round_trip  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_rounding();
      test_field_extremes();
      test_random_mix(220);
      test_window_saturation();
      test_window_recovery();

      req_if.valid <= 1'b0;
      while (exp_pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("run covered %0d samples and %0d checked results, %0d with a full window",
         samples_sent, results_checked, full_window_results);
      $display("largest window sum magnitude seen: %0d", peak_total);
      if (error_count == 0 && exp_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
